// File: design/cctalk_credit_sniffer_unit_assert.svh
// Assertion macros shared by the sniffer RTL.
// Needs i_clk and i_rst_n in the including module's scope.
`ifndef CCTALK_CREDIT_SNIFFER_UNIT_ASSERT_SVH
`define CCTALK_CREDIT_SNIFFER_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset
`define CCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sniffer check failed");

// Next-cycle implication, off during reset
`define CCS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sniffer check failed");

`endif

// File: design/ccs_pkg.sv
// Shared types and constants of the ccTalk credit sniffer.
// No dependencies.
package ccs_pkg;

    localparam int REPLY_BYTES_DEF = 16;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_DEST = 2'd0;
    localparam logic [1:0] REG_SRC  = 2'd1;
    localparam logic [1:0] REG_CMD  = 2'd2;
    localparam logic [1:0] REG_TOP  = 2'd3;

    // Register reset values
    localparam logic [7:0] DEST_RST = 8'd2;
    localparam logic [7:0] SRC_RST  = 8'd1;
    localparam logic [7:0] CMD_RST  = 8'd229;
    localparam logic [7:0] TOP_RST  = 8'd9;

    // Parser phases
    localparam logic [2:0] PH_DEST    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_SRC     = 3'd2;
    localparam logic [2:0] PH_CMD     = 3'd3;
    localparam logic [2:0] PH_CHK     = 3'd4;
    localparam logic [2:0] PH_CAPTURE = 3'd5;

    // Reply byte positions and the code up to which a reply always refreshes the event
    localparam int EVENT_POS  = 4;
    localparam int CODE_POS   = 5;
    localparam int STATUS_POS = 6;
    localparam logic [7:0] UPDATE_TOP_CODE = 8'd10;
    localparam logic [7:0] STATUS_OK_A = 8'd1;
    localparam logic [7:0] STATUS_OK_B = 8'd3;

    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] src;
        logic [7:0] cmd;
        logic [7:0] top;
    } t_ccs_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] coin_code;
        logic [7:0] event_count;
    } t_ccs_credit;

endpackage

// File: design/ccs_rx_if.sv
// Byte channel from the bus receiver into the sniffer.
// No dependencies.
interface ccs_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       session_start;

    modport source (output valid, rx_byte, session_start, input ready);
    modport sink   (input valid, rx_byte, session_start, output ready);
endinterface

// File: design/ccs_cred_if.sv
// Credit report channel out of the sniffer.
// No dependencies.
interface ccs_cred_if;
    logic       valid;
    logic       ready;
    logic [7:0] coin_code;
    logic [7:0] event_count;

    modport source (output valid, coin_code, event_count, input ready);
    modport sink   (input valid, coin_code, event_count, output ready);
endinterface

// File: design/ccs_cfg_if.sv
// Register write channel of the sniffer.
// No dependencies.
interface ccs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/ccs_parser.sv
// Poll frame matcher and reply capture with the credit decision.
// Depends on ccs_pkg and cctalk_credit_sniffer_unit_assert.svh.
`include "cctalk_credit_sniffer_unit_assert.svh"

module ccs_parser #(
    parameter int REPLY_BYTES = ccs_pkg::REPLY_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_byte,
    input  logic                  i_start,
    input  ccs_pkg::t_ccs_cfg     i_cfg,
    output ccs_pkg::t_ccs_credit  o_credit
);
    import ccs_pkg::*;

    localparam int CAP_W = $clog2(REPLY_BYTES);
    localparam logic [CAP_W-1:0] LAST_IDX = CAP_W'(REPLY_BYTES - 1);
    localparam logic [CAP_W-1:0] EVT_IDX  = CAP_W'(EVENT_POS);
    localparam logic [CAP_W-1:0] CODE_IDX = CAP_W'(CODE_POS);
    localparam logic [CAP_W-1:0] STAT_IDX = CAP_W'(STATUS_POS);

    logic [2:0]       r_phase, n_phase;
    logic [CAP_W-1:0] r_idx, n_idx;
    logic [7:0]       r_evt, n_evt;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_stat, n_stat;
    logic [7:0]       r_last, n_last;
    logic             r_known, n_known;

    logic [2:0]       w_phase;
    logic [CAP_W-1:0] w_idx;
    logic [7:0]       w_last;
    logic             w_known;
    logic [7:0]       w_chk;
    logic             w_in_update;
    logic             w_new_evt;

    // Expected checksum of the poll frame (length byte is zero)
    assign w_chk = 8'(8'd0 - i_cfg.dest - i_cfg.src - i_cfg.cmd);

    // Session start clears the parser and the stored event first
    assign w_phase = i_start ? PH_DEST : r_phase;
    assign w_idx   = i_start ? '0 : r_idx;
    assign w_last  = i_start ? 8'd0 : r_last;
    assign w_known = i_start ? 1'b0 : r_known;

    // Capture the reply fields, merging the current byte
    assign n_evt  = (w_phase == PH_CAPTURE && w_idx == EVT_IDX)  ? i_byte : r_evt;
    assign n_code = (w_phase == PH_CAPTURE && w_idx == CODE_IDX) ? i_byte : r_code;
    assign n_stat = (w_phase == PH_CAPTURE && w_idx == STAT_IDX) ? i_byte : r_stat;

    assign w_in_update = (n_code != 8'd0)
        && (n_code <= UPDATE_TOP_CODE || n_code <= i_cfg.top);
    assign w_new_evt = !w_known || (w_last != n_evt);

    // Advance the phase and decide at the last reply byte
    always_comb begin
        n_phase = PH_DEST;
        n_idx = w_idx;
        n_last = w_last;
        n_known = w_known;
        o_credit = '0;
        unique case (w_phase)
            PH_LEN: begin
                n_phase = (i_byte == 8'd0) ? PH_SRC : PH_DEST;
            end
            PH_SRC: begin
                n_phase = (i_byte == i_cfg.src) ? PH_CMD : PH_DEST;
            end
            PH_CMD: begin
                n_phase = (i_byte == i_cfg.cmd) ? PH_CHK : PH_DEST;
            end
            PH_CHK: begin
                n_phase = (i_byte == w_chk) ? PH_CAPTURE : PH_DEST;
                n_idx = '0;
            end
            PH_CAPTURE: begin
                if (w_idx == LAST_IDX) begin
                    n_phase = PH_DEST;
                    n_idx = '0;
                    if (w_in_update && w_new_evt) begin
                        n_last = n_evt;
                        n_known = 1'b1;
                        o_credit.valid = i_take
                            && (n_stat == STATUS_OK_A || n_stat == STATUS_OK_B)
                            && (n_code <= i_cfg.top);
                        o_credit.coin_code = n_code;
                        o_credit.event_count = n_evt;
                    end
                end else begin
                    n_phase = PH_CAPTURE;
                    n_idx = w_idx + 1'b1;
                end
            end
            default: begin
                n_phase = (i_byte == i_cfg.dest) ? PH_LEN : PH_DEST;
            end
        endcase
    end

    // Hold state between beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DEST;
            r_idx <= '0;
            r_last <= 8'd0;
            r_known <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_idx <= n_idx;
            r_last <= n_last;
            r_known <= n_known;
        end
    end

    // Captured reply bytes are always rewritten before they are used
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_evt <= n_evt;
            r_code <= n_code;
            r_stat <= n_stat;
        end
    end

    `CCS_ASSERT_IMP(a_phase_legal, 1'b1, r_phase <= PH_CAPTURE)
    `CCS_ASSERT_IMP(a_idx_only_capture, r_idx != '0, r_phase == PH_CAPTURE)
    `CCS_ASSERT_IMP(a_credit_at_end, o_credit.valid,
        w_phase == PH_CAPTURE && w_idx == LAST_IDX)
    `CCS_ASSERT_NXT(a_credit_known, o_credit.valid,
        r_known && r_last == $past(o_credit.event_count))

endmodule

// File: design/cctalk_credit_sniffer_unit.sv
// ccTalk buffered-credit sniffer: register file, parser and credit output stage.
// Depends on ccs_pkg, the channel interfaces, ccs_parser and the assert header.
// A credit appears on o_cred in the cycle after the last reply byte is taken.
// Throughput: one bus byte per cycle; i_rx.ready is low while a credit waits in
// the output register and o_cred is stalled.
// Reset (synchronous, active low): registers to 2, 1, 229, 9; parser idle, no event.
`include "cctalk_credit_sniffer_unit_assert.svh"

module cctalk_credit_sniffer_unit #(
    parameter int REPLY_BYTES = ccs_pkg::REPLY_BYTES_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ccs_rx_if.sink     i_rx,
    ccs_cfg_if.sink    i_cfg,
    ccs_cred_if.source o_cred
);
    import ccs_pkg::*;

    t_ccs_cfg    r_cfg;
    t_ccs_credit w_credit;
    logic        w_take;
    logic        r_out_valid;
    logic [7:0]  r_out_code;
    logic [7:0]  r_out_evt;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest <= DEST_RST;
            r_cfg.src <= SRC_RST;
            r_cfg.cmd <= CMD_RST;
            r_cfg.top <= TOP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DEST: r_cfg.dest <= i_cfg.data;
                REG_SRC:  r_cfg.src <= i_cfg.data;
                REG_CMD:  r_cfg.cmd <= i_cfg.data;
                REG_TOP:  r_cfg.top <= i_cfg.data;
                default:  r_cfg <= r_cfg;
            endcase
        end
    end

    // Take a byte unless a credit is stuck in the output register
    assign i_rx.ready = !r_out_valid || o_cred.ready;
    assign w_take = i_rx.valid && i_rx.ready;

    ccs_parser #(
        .REPLY_BYTES(REPLY_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_rx.rx_byte),
        .i_start (i_rx.session_start),
        .i_cfg   (r_cfg),
        .o_credit(w_credit)
    );

    // Load a new credit beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_credit.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_cred.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_credit.valid) begin
            r_out_code <= w_credit.coin_code;
            r_out_evt <= w_credit.event_count;
        end
    end

    assign o_cred.valid = r_out_valid;
    assign o_cred.coin_code = r_out_code;
    assign o_cred.event_count = r_out_evt;

    `CCS_ASSERT_IMP(a_ready_stall, !i_rx.ready, r_out_valid && !o_cred.ready)
    `CCS_ASSERT_NXT(a_credit_loads, w_credit.valid,
        r_out_valid && r_out_code == $past(w_credit.coin_code))
    `CCS_ASSERT_IMP(a_credit_code_range, w_credit.valid,
        w_credit.coin_code != 8'd0 && w_credit.coin_code <= r_cfg.top)

endmodule

// File: test/cctalk_credit_sniffer_unit_tb.sv
// Self-checking bench for cctalk_credit_sniffer_unit: bus bytes in, credit reports out.
// Depends on ccs_pkg, cctalk_credit_sniffer_unit and the rx, cfg and cred channel interfaces.
`timescale 1ns / 100ps

module cctalk_credit_sniffer_unit_tb;
    import ccs_pkg::*;

    localparam int REPLY_LEN     = REPLY_BYTES_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int BYTE_TARGET   = 1800;
    localparam int SETTINGS_RUN  = 6;

    typedef struct packed {
        logic [7:0] coin;
        logic [7:0] evt;
    } credit_t;

    // One directed bus byte; typed rows carry the credit they must produce
    typedef struct packed {
        logic [7:0] b;
        logic       s;
        logic       typed;
        logic [7:0] coin;
        logic [7:0] evt;
    } row_t;

    // Default poll frame after a dropped partial one, then a reply with
    // bytes at both extremes and a fresh event, top code and status 3
    localparam row_t PLAN [24] = '{
        '{8'd2,   1'b1, 1'b0, 8'd0, 8'd0},
        '{8'd0,   1'b0, 1'b0, 8'd0, 8'd0},
        '{8'd2,   1'b0, 1'b0, 8'd0, 8'd0},
        '{8'd2,   1'b0, 1'b0, 8'd0, 8'd0},
        '{8'd0,   1'b0, 1'b0, 8'd0, 8'd0},
        '{8'd1,   1'b0, 1'b0, 8'd0, 8'd0},
        '{8'd229, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'd24,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hFF,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hFF,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hFF,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'd9,   1'b0, 1'b0, 8'd0, 8'd0},
        '{8'd3,   1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hFF,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hFF,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hFF,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hFF,  1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h5A,  1'b0, 1'b1, 8'd9, 8'd255}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ccs_rx_if   rx_bus ();
    ccs_cfg_if  cfg_bus ();
    ccs_cred_if cred_bus ();

    cctalk_credit_sniffer_unit #(
        .REPLY_BYTES(REPLY_LEN)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_bus),
        .i_cfg   (cfg_bus),
        .o_cred  (cred_bus)
    );

    // Credits the sniffer still owes, oldest first
    credit_t credits_due [$];

    // Shadow copy of the registers and the parser
    t_ccs_cfg   mdl_cfg;
    logic [2:0] mdl_phase;
    logic [4:0] mdl_idx;
    logic [7:0] mdl_evt;
    logic [7:0] mdl_code;
    logic [7:0] mdl_status;
    logic [7:0] mdl_last_evt;
    logic       mdl_evt_known;

    int errors        = 0;
    int bytes_sent    = 0;
    int credits_total = 0;
    int credits_seen  = 0;
    int cycle_cnt     = 0;
    int gap_pct       = 0;
    int stall_pct     = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH at %0t: %s, got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic logic [7:0] poll_sum(input t_ccs_cfg c);
        return 8'd0 - (c.dest + c.src + c.cmd);
    endfunction

    function automatic void clear_session();
        mdl_phase     = PH_DEST;
        mdl_idx       = '0;
        mdl_evt       = '0;
        mdl_code      = '0;
        mdl_status    = '0;
        mdl_last_evt  = '0;
        mdl_evt_known = 1'b0;
    endfunction

    function automatic logic pick_start();
        return $urandom_range(0, 99) < 1;
    endfunction

    // Advance the parser by one bus byte; returns 1 with the credit it reports
    function automatic bit sniff_byte(input logic [7:0] b, input logic s,
                                      output credit_t cr);
        logic in_update;
        bit   hit;
        hit = 1'b0;
        cr  = '0;
        if (s) clear_session();
        case (mdl_phase)
            PH_LEN: mdl_phase = (b == 8'd0) ? PH_SRC : PH_DEST;
            PH_SRC: mdl_phase = (b == mdl_cfg.src) ? PH_CMD : PH_DEST;
            PH_CMD: mdl_phase = (b == mdl_cfg.cmd) ? PH_CHK : PH_DEST;
            PH_CHK: begin
                if (b == poll_sum(mdl_cfg)) begin
                    mdl_phase = PH_CAPTURE;
                    mdl_idx   = '0;
                end else begin
                    mdl_phase = PH_DEST;
                end
            end
            PH_CAPTURE: begin
                if (mdl_idx == EVENT_POS)  mdl_evt    = b;
                if (mdl_idx == CODE_POS)   mdl_code   = b;
                if (mdl_idx == STATUS_POS) mdl_status = b;
                if (int'(mdl_idx) + 1 >= REPLY_LEN) begin
                    in_update = (mdl_code != 8'd0) &&
                                (mdl_code <= UPDATE_TOP_CODE || mdl_code <= mdl_cfg.top);
                    mdl_phase = PH_DEST;
                    mdl_idx   = '0;
                    if (in_update && (!mdl_evt_known || mdl_last_evt != mdl_evt)) begin
                        mdl_last_evt  = mdl_evt;
                        mdl_evt_known = 1'b1;
                        if ((mdl_status == STATUS_OK_A || mdl_status == STATUS_OK_B) &&
                            mdl_code <= mdl_cfg.top) begin
                            hit = 1'b1;
                            cr  = '{coin: mdl_code, evt: mdl_evt};
                        end
                    end
                end else begin
                    mdl_idx = mdl_idx + 5'd1;
                end
            end
            default: mdl_phase = (b == mdl_cfg.dest) ? PH_LEN : PH_DEST;
        endcase
        return hit;
    endfunction

    // Offer one bus byte, hold it until taken, then maybe idle a burst
    task automatic push_byte(input logic [7:0] b, input logic s,
                             input logic typed, input credit_t want);
        credit_t cr;
        bit      hit;
        rx_bus.valid         <= 1'b1;
        rx_bus.rx_byte       <= b;
        rx_bus.session_start <= s;
        do @(posedge i_clk); while (!(rx_bus.valid && rx_bus.ready));
        bytes_sent++;
        hit = sniff_byte(b, s, cr);
        if (typed) begin
            credits_due.push_back(want);
            credits_total++;
        end else if (hit) begin
            credits_due.push_back(cr);
            credits_total++;
        end
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            rx_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [7:0] v);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= v;
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        case (idx)
            REG_DEST: mdl_cfg.dest = v;
            REG_SRC:  mdl_cfg.src  = v;
            REG_CMD:  mdl_cfg.cmd  = v;
            default:  mdl_cfg.top  = v;
        endcase
    endtask

    // Drain all owed credits, let the last byte settle, then load a new setting
    task automatic load_cfg(input t_ccs_cfg c);
        rx_bus.valid <= 1'b0;
        while (credits_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        put_reg(REG_DEST, c.dest);
        put_reg(REG_SRC, c.src);
        put_reg(REG_CMD, c.cmd);
        put_reg(REG_TOP, c.top);
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly well-formed poll plus reply; some corrupted polls and plain noise
    task automatic send_frame();
        logic [7:0] poll [5];
        logic [7:0] reply [REPLY_LEN];
        int kind;
        int p;
        int n;
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                push_byte(($urandom_range(0, 3) == 0) ? mdl_cfg.dest : 8'($urandom),
                          pick_start(), 1'b0, '0);
            end
            return;
        end
        poll[0] = mdl_cfg.dest;
        poll[1] = 8'd0;
        poll[2] = mdl_cfg.src;
        poll[3] = mdl_cfg.cmd;
        poll[4] = poll_sum(mdl_cfg);
        if (kind >= 80) begin
            p = $urandom_range(0, 4);
            poll[p] = poll[p] ^ 8'($urandom_range(1, 255));
        end
        foreach (reply[i]) reply[i] = 8'($urandom);
        reply[EVENT_POS] = ($urandom_range(0, 9) < 3) ? mdl_last_evt : 8'($urandom);
        case ($urandom_range(0, 9))
            0:       reply[CODE_POS] = 8'd0;
            1:       reply[CODE_POS] = UPDATE_TOP_CODE;
            2:       reply[CODE_POS] = mdl_cfg.top + 8'd1;
            3:       reply[CODE_POS] = 8'd255;
            default: reply[CODE_POS] = 8'($urandom_range(1, mdl_cfg.top));
        endcase
        case ($urandom_range(0, 9))
            0:       reply[STATUS_POS] = 8'd0;
            1:       reply[STATUS_POS] = 8'd2;
            2:       reply[STATUS_POS] = 8'($urandom);
            3, 4, 5: reply[STATUS_POS] = STATUS_OK_B;
            default: reply[STATUS_POS] = STATUS_OK_A;
        endcase
        // now and then cut the reply short
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, REPLY_LEN - 1) : REPLY_LEN;
        foreach (poll[i]) push_byte(poll[i], pick_start(), 1'b0, '0);
        for (int i = 0; i < n; i++) push_byte(reply[i], pick_start(), 1'b0, '0);
    endtask

    // Credit sink: check each beat against the oldest owed credit, stall in bursts
    always @(posedge i_clk) begin
        credit_t want;
        int      stall_left;
        if (i_rst_n && cred_bus.valid && cred_bus.ready) begin
            if (credits_due.size() == 0) begin
                flag_mismatch("credit with none owed, coin", cred_bus.coin_code, -1);
            end else begin
                want = credits_due.pop_front();
                credits_seen++;
                if (cred_bus.coin_code !== want.coin)
                    flag_mismatch("coin_code", cred_bus.coin_code, want.coin);
                if (cred_bus.event_count !== want.evt)
                    flag_mismatch("event_count", cred_bus.event_count, want.evt);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 19);
        end
        cred_bus.ready <= (stall_left == 0);
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d credits still owed", cycle_cnt,
                 credits_due.size());
        $display("== FAIL ==");
        $finish;
    end

    // Main sequence
    initial begin
        t_ccs_cfg c;
        int       phase_start;
        int       next_shuffle;
        int       r;
        i_rst_n              = 1'b0;
        rx_bus.valid         = 1'b0;
        rx_bus.rx_byte       = '0;
        rx_bus.session_start = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_DEST;
        cfg_bus.data         = '0;
        cred_bus.ready       = 1'b0;
        mdl_cfg = '{dest: DEST_RST, src: SRC_RST, cmd: CMD_RST, top: TOP_RST};
        clear_session();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset register values
        gap_pct   = 20;
        stall_pct = 20;
        foreach (PLAN[i]) begin
            push_byte(PLAN[i].b, PLAN[i].s, PLAN[i].typed,
                      '{coin: PLAN[i].coin, evt: PLAN[i].evt});
        end

        // Random frames, one register setting per stretch; the last one runs calm
        next_shuffle = bytes_sent;
        for (int ph = 0; ph < SETTINGS_RUN; ph++) begin
            case (ph)
                0: c = mdl_cfg;
                1: c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
                2: c = '{8'h00, 8'h00, 8'h00, 8'h00};
                3: c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'd1};
                4: c = '{8'($urandom), 8'($urandom), 8'($urandom), UPDATE_TOP_CODE};
                default: c = '{8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom_range(9, 255))};
            endcase
            if (ph > 0) load_cfg(c);
            if (ph == SETTINGS_RUN - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTE_TARGET / SETTINGS_RUN) begin
                // reshuffle idling every few dozen bytes, sometimes to none at all
                if (ph < SETTINGS_RUN - 1 && bytes_sent >= next_shuffle) begin
                    r = $urandom_range(0, 2);
                    gap_pct      = (r == 0) ? 0 : ((r == 1) ? 10 : 30);
                    stall_pct    = (r == 0) ? 0 : ((r == 1) ? 10 : 40);
                    next_shuffle = bytes_sent + 60;
                end
                send_frame();
            end
        end

        // Drain and let the pipeline settle
        rx_bus.valid <= 1'b0;
        while (credits_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d bus bytes under %0d register settings.",
                 bytes_sent, SETTINGS_RUN);
        $display("Checked %0d credit reports; %0d mismatches.", credits_seen, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
